### rtl/core/ramx_pkg.sv
// shared opcodes, command and status types for the ram machine execute unit
// no dependencies; dp, ctrl and top use scoped names, the testbench imports it
`timescale 1ns / 1ps

package ramx_pkg;

    // instruction opcodes
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_MOVE   = 4'd4;
    localparam logic [3:0] OP_ILOAD  = 4'd5;
    localparam logic [3:0] OP_ISTORE = 4'd6;
    localparam logic [3:0] OP_CONST  = 4'd7;
    localparam logic [3:0] OP_JUMP   = 4'd8;
    localparam logic [3:0] OP_CJUMP  = 4'd9;
    localparam logic [3:0] OP_HALT   = 4'd10;

    // program positions are cut to this width, then to the 16-bit field
    localparam int          POSITION_WIDTH = 16;
    localparam int          POS_EFF_W      = (POSITION_WIDTH < 16) ? POSITION_WIDTH : 16;
    localparam logic [15:0] POS_MASK       = 16'((32'd1 << POS_EFF_W) - 32'd1);

    // memory port operations
    localparam logic [1:0] MEM_IDLE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;
    localparam logic [1:0] MEM_CLEAR = 2'd3;

    // memory address select
    localparam logic [1:0] ASEL_SRC = 2'd0;
    localparam logic [1:0] ASEL_DST = 2'd1;
    localparam logic [1:0] ASEL_IND = 2'd2;

    // address reduction source (and target)
    localparam logic [1:0] RSEL_A1 = 2'd0;  // first operand -> source address
    localparam logic [1:0] RSEL_A2 = 2'd1;  // second operand -> destination address
    localparam logic [1:0] RSEL_VA = 2'd2;  // source word -> indirect address
    localparam logic [1:0] RSEL_VB = 2'd3;  // destination word -> destination address

    typedef struct packed {
        logic       capture;
        logic [1:0] mem_op;
        logic [1:0] addr_sel;
        logic [1:0] red_sel;
        logic       red_div_start;
        logic       red_take;
        logic       ld_va;
        logic       ld_vb;
        logic       alu_ld;
        logic       mul_init;
        logic       mul_step;
        logic       div_start;
        logic       div_take;
        logic       val_from_mem;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       va_zero;
        logic       clr_last;
        logic       div_done;
    } t_status;

endpackage

### rtl/core/ramx_div.sv
// iterative restoring unsigned divider, one quotient bit per cycle
// standalone; shared for word division and address reduction
`timescale 1ns / 1ps

module ramx_div #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);

    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quot;
    logic [W-1:0]  r_dvs;

    logic [W:0]    shifted;
    logic [W+1:0]  diff;

    assign shifted = {r_rem, r_quot[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            if (diff[W+1]) begin
                r_rem  <= shifted[W-1:0];
                r_quot <= {r_quot[W-2:0], 1'b0};
            end else begin
                r_rem  <= diff[W-1:0];
                r_quot <= {r_quot[W-2:0], 1'b1};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

### rtl/core/ramx_dp.sv
// datapath: operand registers, data memory, shift-add multiplier, result registers
// uses ramx_pkg (command/status types, codes) and instantiates ramx_div
`timescale 1ns / 1ps

module ramx_dp #(
    parameter int MEM_DEPTH  = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ramx_pkg::t_cmd      i_cmd,
    output ramx_pkg::t_status   o_status,
    input  logic [3:0]          i_opcode,
    input  logic signed [31:0]  i_first_operand,
    input  logic [15:0]         i_second_operand,
    input  logic [15:0]         i_fallthrough_position,
    output logic                o_done,
    output logic [15:0]         o_next_position,
    output logic signed [31:0]  o_data_value,
    output logic                o_halted,
    output logic                o_divide_by_zero
);

    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int DW         = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;
    localparam bit DEPTH_POW2 = ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0);

    // captured instruction
    logic [3:0]            r_op;
    logic [31:0]           r_a1;
    logic [15:0]           r_a2;
    logic [15:0]           r_fall;

    // addresses and operand words
    logic [AW-1:0]         r_src;
    logic [AW-1:0]         r_dst;
    logic [AW-1:0]         r_ia;
    logic [AW-1:0]         r_clr;
    logic [WORD_WIDTH-1:0] r_va;
    logic [WORD_WIDTH-1:0] r_vb;
    logic [WORD_WIDTH-1:0] r_val;
    logic [WORD_WIDTH-1:0] r_mc;
    logic [WORD_WIDTH-1:0] r_mp;

    // data memory
    logic [WORD_WIDTH-1:0] r_mem [MEM_DEPTH];
    logic [WORD_WIDTH-1:0] r_rdata;
    logic [AW-1:0]         sel_addr;
    logic [AW-1:0]         mem_addr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_we;

    // result registers
    logic                  r_done;
    logic [15:0]           r_next;
    logic [31:0]           r_data;
    logic                  r_halted;
    logic                  r_dz;
    logic [15:0]           n_next;
    logic [31:0]           n_data;

    // arithmetic
    logic [DW-1:0]         red_val;
    logic [AW-1:0]         red_addr;
    logic                  va_neg;
    logic                  vb_neg;
    logic                  va_zero;
    logic [WORD_WIDTH-1:0] mag_a;
    logic [WORD_WIDTH-1:0] mag_b;
    logic [WORD_WIDTH-1:0] q_word;
    logic [WORD_WIDTH-1:0] q_fixed;
    logic [63:0]           a1_sx;
    logic [WORD_WIDTH-1:0] alu_val;
    logic [WORD_WIDTH-1:0] res_value;
    logic [63:0]           res_sx;
    logic [DW-1:0]         div_dividend;
    logic [DW-1:0]         div_divisor;
    logic                  div_done;
    logic [DW-1:0]         div_quot;
    logic [DW-1:0]         div_rem;

    assign va_neg  = r_va[WORD_WIDTH-1];
    assign vb_neg  = r_vb[WORD_WIDTH-1];
    assign va_zero = (r_va == '0);
    assign mag_a   = va_neg ? (WORD_WIDTH'(0) - r_va) : r_va;
    assign mag_b   = vb_neg ? (WORD_WIDTH'(0) - r_vb) : r_vb;
    assign q_word  = div_quot[WORD_WIDTH-1:0];
    assign q_fixed = (va_neg ^ vb_neg) ? (WORD_WIDTH'(0) - q_word) : q_word;
    assign a1_sx   = 64'($signed(r_a1));

    // value to reduce modulo the memory depth
    always_comb begin
        case (i_cmd.red_sel)
            ramx_pkg::RSEL_A1: red_val = DW'(r_a1);
            ramx_pkg::RSEL_A2: red_val = DW'(r_a2);
            ramx_pkg::RSEL_VA: red_val = DW'(r_va);
            default:           red_val = DW'(r_vb);
        endcase
    end

    assign red_addr = DEPTH_POW2 ? red_val[AW-1:0] : div_rem[AW-1:0];

    assign div_dividend = i_cmd.red_div_start ? red_val : DW'(mag_b);
    assign div_divisor  = i_cmd.red_div_start ? DW'(MEM_DEPTH) : DW'(mag_a);

    ramx_div #(
        .W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.red_div_start | i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_comb begin
        case (r_op)
            ramx_pkg::OP_ADD:   alu_val = r_vb + r_va;
            ramx_pkg::OP_SUB:   alu_val = r_vb - r_va;
            ramx_pkg::OP_CONST: alu_val = a1_sx[WORD_WIDTH-1:0];
            default:            alu_val = r_va;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_a1   <= i_first_operand;
            r_a2   <= i_second_operand;
            r_fall <= i_fallthrough_position;
        end
        if (i_cmd.red_take) begin
            case (i_cmd.red_sel)
                ramx_pkg::RSEL_A1: r_src <= red_addr;
                ramx_pkg::RSEL_VA: r_ia  <= red_addr;
                default:           r_dst <= red_addr;
            endcase
        end
        if (i_cmd.ld_va) begin
            r_va <= r_rdata;
        end
        if (i_cmd.ld_vb) begin
            r_vb <= r_rdata;
        end
        if (i_cmd.alu_ld) begin
            r_val <= alu_val;
        end else if (i_cmd.mul_init) begin
            r_val <= '0;
        end else if (i_cmd.mul_step) begin
            r_val <= r_val + (r_mp[0] ? r_mc : '0);
        end else if (i_cmd.div_take) begin
            r_val <= q_fixed;
        end else if (i_cmd.val_from_mem) begin
            r_val <= r_rdata;
        end
        if (i_cmd.mul_init) begin
            r_mc <= r_va;
            r_mp <= r_vb;
        end else if (i_cmd.mul_step) begin
            r_mc <= {r_mc[WORD_WIDTH-2:0], 1'b0};
            r_mp <= {1'b0, r_mp[WORD_WIDTH-1:1]};
        end
    end

    // single-port memory with registered read
    always_comb begin
        case (i_cmd.addr_sel)
            ramx_pkg::ASEL_SRC: sel_addr = r_src;
            ramx_pkg::ASEL_IND: sel_addr = r_ia;
            default:            sel_addr = r_dst;
        endcase
    end

    assign mem_addr  = (i_cmd.mem_op == ramx_pkg::MEM_CLEAR) ? r_clr : sel_addr;
    assign mem_wdata = (i_cmd.mem_op == ramx_pkg::MEM_CLEAR) ? '0 : r_val;
    assign mem_we    = (i_cmd.mem_op == ramx_pkg::MEM_WRITE) ||
                       (i_cmd.mem_op == ramx_pkg::MEM_CLEAR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.mem_op == ramx_pkg::MEM_CLEAR) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    // result formation
    always_comb begin
        case (r_op)
            ramx_pkg::OP_ADD, ramx_pkg::OP_SUB, ramx_pkg::OP_MUL, ramx_pkg::OP_DIV,
            ramx_pkg::OP_MOVE, ramx_pkg::OP_ILOAD, ramx_pkg::OP_ISTORE,
            ramx_pkg::OP_CONST: n_next = r_fall & ramx_pkg::POS_MASK;
            ramx_pkg::OP_JUMP:  n_next = r_a2 & ramx_pkg::POS_MASK;
            ramx_pkg::OP_CJUMP: n_next = (va_zero ? r_a2 : r_fall) & ramx_pkg::POS_MASK;
            default:            n_next = '0;
        endcase
        case (r_op)
            ramx_pkg::OP_ADD, ramx_pkg::OP_SUB, ramx_pkg::OP_MUL, ramx_pkg::OP_MOVE,
            ramx_pkg::OP_ILOAD, ramx_pkg::OP_ISTORE,
            ramx_pkg::OP_CONST: res_value = r_val;
            ramx_pkg::OP_DIV:   res_value = va_zero ? '0 : r_val;
            ramx_pkg::OP_CJUMP: res_value = r_va;
            default:            res_value = '0;
        endcase
        res_sx = 64'($signed(res_value));
        n_data = res_sx[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_next   <= n_next;
            r_data   <= n_data;
            r_halted <= (r_op > ramx_pkg::OP_CJUMP);
            r_dz     <= (r_op == ramx_pkg::OP_DIV) && va_zero;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.va_zero  = va_zero;
    assign o_status.clr_last = (r_clr == AW'(MEM_DEPTH - 1));
    assign o_status.div_done = div_done;

    assign o_done           = r_done;
    assign o_next_position  = r_next;
    assign o_data_value     = r_data;
    assign o_halted         = r_halted;
    assign o_divide_by_zero = r_dz;

endmodule

### rtl/core/ramx_ctrl.sv
// controller: state machine that sequences one instruction through the datapath
// uses ramx_pkg for the command/status structs and codes
`timescale 1ns / 1ps

module ramx_ctrl #(
    parameter int MEM_DEPTH  = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output ramx_pkg::t_cmd    o_cmd,
    input  ramx_pkg::t_status i_status
);

    localparam int CW         = $clog2(WORD_WIDTH);
    localparam bit DEPTH_POW2 = ((MEM_DEPTH & (MEM_DEPTH - 1)) == 0);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_RED_GO   = 4'd2;
    localparam logic [3:0] S_RED_WAIT = 4'd3;
    localparam logic [3:0] S_RD_A     = 4'd4;
    localparam logic [3:0] S_LD_A     = 4'd5;
    localparam logic [3:0] S_LD_B     = 4'd6;
    localparam logic [3:0] S_EXEC     = 4'd7;
    localparam logic [3:0] S_MUL      = 4'd8;
    localparam logic [3:0] S_DIV_WAIT = 4'd9;
    localparam logic [3:0] S_IND_RD   = 4'd10;
    localparam logic [3:0] S_IND_LD   = 4'd11;
    localparam logic [3:0] S_WRITE    = 4'd12;

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    logic [1:0]    r_red_sel;
    logic [1:0]    n_red_sel;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [3:0]    red_next;

    // where to go once an address reduction is done
    always_comb begin
        case (r_red_sel)
            ramx_pkg::RSEL_A1: red_next = S_RED_GO;
            ramx_pkg::RSEL_A2: red_next = S_RD_A;
            ramx_pkg::RSEL_VA: red_next = S_IND_RD;
            default:           red_next = S_WRITE;
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_red_sel      = r_red_sel;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.red_sel  = r_red_sel;
        o_cmd.mem_op   = ramx_pkg::MEM_IDLE;
        o_cmd.addr_sel = ramx_pkg::ASEL_DST;
        case (r_state)
            S_CLEAR: begin
                o_cmd.mem_op = ramx_pkg::MEM_CLEAR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_red_sel     = ramx_pkg::RSEL_A1;
                    n_state       = S_RED_GO;
                end
            end
            S_RED_GO: begin
                if (DEPTH_POW2) begin
                    o_cmd.red_take = 1'b1;
                    n_state        = red_next;
                    if (r_red_sel == ramx_pkg::RSEL_A1) begin
                        n_red_sel = ramx_pkg::RSEL_A2;
                    end
                end else begin
                    o_cmd.red_div_start = 1'b1;
                    n_state             = S_RED_WAIT;
                end
            end
            S_RED_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.red_take = 1'b1;
                    n_state        = red_next;
                    if (r_red_sel == ramx_pkg::RSEL_A1) begin
                        n_red_sel = ramx_pkg::RSEL_A2;
                    end
                end
            end
            S_RD_A: begin
                o_cmd.mem_op   = ramx_pkg::MEM_READ;
                o_cmd.addr_sel = ramx_pkg::ASEL_SRC;
                n_state        = S_LD_A;
            end
            S_LD_A: begin
                o_cmd.ld_va    = 1'b1;
                o_cmd.mem_op   = ramx_pkg::MEM_READ;
                o_cmd.addr_sel = ramx_pkg::ASEL_DST;
                n_state        = S_LD_B;
            end
            S_LD_B: begin
                o_cmd.ld_vb = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                case (i_status.op)
                    ramx_pkg::OP_ADD, ramx_pkg::OP_SUB, ramx_pkg::OP_MOVE,
                    ramx_pkg::OP_CONST: begin
                        o_cmd.alu_ld = 1'b1;
                        n_state      = S_WRITE;
                    end
                    ramx_pkg::OP_ISTORE: begin
                        o_cmd.alu_ld = 1'b1;
                        n_red_sel    = ramx_pkg::RSEL_VB;
                        n_state      = S_RED_GO;
                    end
                    ramx_pkg::OP_ILOAD: begin
                        n_red_sel = ramx_pkg::RSEL_VA;
                        n_state   = S_RED_GO;
                    end
                    ramx_pkg::OP_MUL: begin
                        o_cmd.mul_init = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_MUL;
                    end
                    ramx_pkg::OP_DIV: begin
                        if (i_status.va_zero) begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV_WAIT;
                        end
                    end
                    default: begin
                        // jump, cjump, halt and undefined codes write nothing
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(WORD_WIDTH - 1)) begin
                    n_state = S_WRITE;
                end
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state        = S_WRITE;
                end
            end
            S_IND_RD: begin
                o_cmd.mem_op   = ramx_pkg::MEM_READ;
                o_cmd.addr_sel = ramx_pkg::ASEL_IND;
                n_state        = S_IND_LD;
            end
            S_IND_LD: begin
                o_cmd.val_from_mem = 1'b1;
                n_state            = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.mem_op   = ramx_pkg::MEM_WRITE;
                o_cmd.addr_sel = ramx_pkg::ASEL_DST;
                o_cmd.finish   = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_red_sel <= ramx_pkg::RSEL_A1;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_red_sel <= n_red_sel;
            r_cnt     <= n_cnt;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### rtl/core/ram_machine_instruction_execute_unit.sv
// ram machine execute unit: one instruction per request, busy until its result strobes.
// the shift-add multiplier and the iterative divider serve multiply and divide; for depths that
// are not a power of two the divider also reduces each address modulo MEM_DEPTH.
// reset: synchronous active low; then a clearing pass zeroes all MEM_DEPTH memory words.
// results show on o_done for one cycle and cannot be stalled
`timescale 1ns / 1ps

module ram_machine_instruction_execute_unit #(
    parameter int MEM_DEPTH  = 256,
    parameter int WORD_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               start,
    output logic               busy,
    input  logic [3:0]         i_opcode,
    input  logic signed [31:0] i_first_operand,
    input  logic [15:0]        i_second_operand,
    input  logic [15:0]        i_fallthrough_position,
    // result side, one-cycle strobe
    output logic               o_done,
    output logic [15:0]        o_next_position,
    output logic signed [31:0] o_data_value,
    output logic               o_halted,
    output logic               o_divide_by_zero
);

    // command and status between the sequencer and the datapath
    ramx_pkg::t_cmd    cmd;
    ramx_pkg::t_status status;

    // sequencer: clear pass, address reduction, operand reads, execute, write back
    ramx_ctrl #(
        .MEM_DEPTH  (MEM_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .o_cmd    (cmd),
        .i_status (status)
    );

    // datapath: memory, operand registers, multiplier, divider, result registers
    ramx_dp #(
        .MEM_DEPTH  (MEM_DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (cmd),
        .o_status               (status),
        .i_opcode               (i_opcode),
        .i_first_operand        (i_first_operand),
        .i_second_operand       (i_second_operand),
        .i_fallthrough_position (i_fallthrough_position),
        .o_done                 (o_done),
        .o_next_position        (o_next_position),
        .o_data_value           (o_data_value),
        .o_halted               (o_halted),
        .o_divide_by_zero       (o_divide_by_zero)
    );

`ifndef SYNTHESIS
    // a result only follows a cycle in which the unit was working
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in progress");

    // an accepted request keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // halt always sends the program back to position zero
    a_halt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_halted) |-> (o_next_position == 16'd0))
        else $error("halt result with nonzero next position");

    // halt and divide-by-zero come from different opcodes
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_halted && o_divide_by_zero))
        else $error("halt and divide-by-zero flagged together");

    // a suppressed division reports a zero word
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_divide_by_zero) |-> (o_data_value == 32'sd0))
        else $error("divide-by-zero result with nonzero data");
`endif

endmodule

### sim/testbench.sv
// self-checking testbench for ram_machine_instruction_execute_unit: directed and random requests
// depends on ramx_pkg for the opcodes and the position mask, and on the unit itself
`timescale 1ns / 1ps

import ramx_pkg::*;

typedef struct packed {
    logic [15:0] next_pos;
    logic [31:0] value;
    logic        halted;
    logic        dz;
} exec_outcome_t;

// keeps a private copy of the data memory and the outcomes still owed by the unit
class ram_exec_scoreboard #(int DEPTH = 256);
    logic [31:0]   words [DEPTH];
    exec_outcome_t outcomes_due [$];
    int            errors;

    function new();
        foreach (words[i]) words[i] = '0;
        errors = 0;
    endfunction

    // signed quotient through magnitudes; min / -1 comes back as min
    function logic [31:0] quotient(logic [31:0] num, logic [31:0] den);
        logic [31:0] un, ud, q;
        un = num[31] ? -num : num;
        ud = den[31] ? -den : den;
        q  = un / ud;
        return (num[31] != den[31]) ? -q : q;
    endfunction

    function void take_instruction(logic [3:0] op, logic [31:0] a1, logic [15:0] a2,
                                   logic [15:0] fall);
        int unsigned   src, dst;
        logic [31:0]   va, vb;
        logic          store;
        exec_outcome_t res;
        src   = a1 % DEPTH;
        dst   = a2 % DEPTH;
        va    = words[src];
        vb    = words[dst];
        store = 1'b0;
        res   = '{next_pos: fall & POS_MASK, value: '0, halted: 1'b0, dz: 1'b0};
        case (op)
            OP_ADD: begin
                res.value = vb + va;
                store     = 1'b1;
            end
            OP_SUB: begin
                res.value = vb - va;
                store     = 1'b1;
            end
            OP_MUL: begin
                res.value = vb * va;
                store     = 1'b1;
            end
            OP_DIV: begin
                // zero divisor suppresses the write and falls through
                if (va == '0) begin
                    res.dz = 1'b1;
                end else begin
                    res.value = quotient(vb, va);
                    store     = 1'b1;
                end
            end
            OP_MOVE: begin
                res.value = va;
                store     = 1'b1;
            end
            OP_ILOAD: begin
                res.value = words[va % DEPTH];
                store     = 1'b1;
            end
            OP_ISTORE: begin
                res.value = va;
                dst       = vb % DEPTH;
                store     = 1'b1;
            end
            OP_CONST: begin
                res.value = a1;
                store     = 1'b1;
            end
            OP_JUMP: begin
                res.next_pos = a2 & POS_MASK;
            end
            OP_CJUMP: begin
                res.value = va;
                if (va == '0) res.next_pos = a2 & POS_MASK;
            end
            default: begin
                // halt, and every undefined opcode behaves the same
                res.halted   = 1'b1;
                res.next_pos = '0;
            end
        endcase
        if (store) words[dst] = res.value;
        outcomes_due.push_back(res);
    endfunction

    function void check_outcome(logic [15:0] next_pos, logic [31:0] value, logic halted,
                                logic dz);
        exec_outcome_t want;
        if (outcomes_due.size() == 0) begin
            $error("result strobe with no request outstanding: next_position %0h data_value %0h",
                   next_pos, value);
            errors++;
            return;
        end
        want = outcomes_due.pop_front();
        if (next_pos !== want.next_pos) begin
            $error("next_position expected %0h actual %0h", want.next_pos, next_pos);
            errors++;
        end
        if (value !== want.value) begin
            $error("data_value expected %0d actual %0d", $signed(want.value), $signed(value));
            errors++;
        end
        if (halted !== want.halted) begin
            $error("halted expected %0b actual %0b", want.halted, halted);
            errors++;
        end
        if (dz !== want.dz) begin
            $error("divide_by_zero expected %0b actual %0b", want.dz, dz);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int MEM_DEPTH       = 256;
    localparam int WORD_WIDTH      = 32;
    localparam int RANDOM_REQUESTS = 850;
    localparam int QUIET_TAIL      = 120;   // last requests go back to back
    localparam int DRAIN_CYCLES    = 64;    // extra wait once no outcome is still owed
    localparam int CYCLE_LIMIT     = 300000;

    // opcodes with no defined meaning, executed as halt
    localparam logic [3:0] OP_RESERVED_FIRST = 4'd11;
    localparam logic [3:0] OP_RESERVED_LAST  = 4'd15;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         i_opcode;
    logic signed [31:0] i_first_operand;
    logic [15:0]        i_second_operand;
    logic [15:0]        i_fallthrough_position;
    logic               o_done;
    logic [15:0]        o_next_position;
    logic signed [31:0] o_data_value;
    logic               o_halted;
    logic               o_divide_by_zero;

    int unsigned cycle_count = 0;

    ram_exec_scoreboard #(MEM_DEPTH) sb;

    ram_machine_instruction_execute_unit #(
        .MEM_DEPTH (MEM_DEPTH),
        .WORD_WIDTH(WORD_WIDTH)
    ) DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .start                 (start),
        .busy                  (busy),
        .i_opcode              (i_opcode),
        .i_first_operand       (i_first_operand),
        .i_second_operand      (i_second_operand),
        .i_fallthrough_position(i_fallthrough_position),
        .o_done                (o_done),
        .o_next_position       (o_next_position),
        .o_data_value          (o_data_value),
        .o_halted              (o_halted),
        .o_divide_by_zero      (o_divide_by_zero)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // results cannot be held off, so every strobe is checked on the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_done !== 1'b0)
            sb.check_outcome(o_next_position, o_data_value, o_halted, o_divide_by_zero);
    end

    // start stays high from one request to the next; it drops only in a hold-off and after the last request
    task automatic send_instruction(input logic [3:0] op, input logic [31:0] a1,
                                    input logic [15:0] a2, input logic [15:0] fall);
        @(negedge i_clk);
        start                  <= 1'b1;
        i_opcode               <= op;
        i_first_operand        <= a1;
        i_second_operand       <= a2;
        i_fallthrough_position <= fall;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.take_instruction(op, a1, a2, fall);
    endtask

    task automatic hold_off(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // mostly a small pool of addresses so that values meet again
    function automatic logic [7:0] pool_address();
        return ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    endfunction

    // upper bits are dropped by the address wrap, so they are noise
    function automatic logic [31:0] address_word();
        logic [23:0] upper;
        upper = $urandom_range(0, 1) ? 24'($urandom) : 24'd0;
        return {upper, pool_address()};
    endfunction

    function automatic logic [31:0] constant_word();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 32'($urandom_range(0, 15));
        if (pick == 5) return -32'($urandom_range(1, 16));
        if (pick == 6) return 32'h7fff_ffff;
        if (pick == 7) return 32'h8000_0000;
        return $urandom;
    endfunction

    task automatic send_random();
        int unsigned pick;
        logic [3:0]  op;
        logic [31:0] a1;
        logic [15:0] a2;
        logic [7:0]  a2_upper;
        pick = $urandom_range(0, 99);
        if (pick < 18)      op = OP_CONST;
        else if (pick < 28) op = OP_ADD;
        else if (pick < 36) op = OP_SUB;
        else if (pick < 44) op = OP_MUL;
        else if (pick < 56) op = OP_DIV;
        else if (pick < 64) op = OP_MOVE;
        else if (pick < 71) op = OP_ILOAD;
        else if (pick < 78) op = OP_ISTORE;
        else if (pick < 84) op = OP_JUMP;
        else if (pick < 92) op = OP_CJUMP;
        else if (pick < 96) op = OP_HALT;
        else                op = 4'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
        a1       = (op == OP_CONST) ? constant_word() : address_word();
        a2_upper = $urandom_range(0, 1) ? 8'($urandom) : 8'd0;
        a2       = (op == OP_JUMP || op == OP_CJUMP) ? 16'($urandom)
                                                     : {a2_upper, pool_address()};
        send_instruction(op, a1, a2, 16'($urandom));
    endtask

    initial begin
        sb                     = new();
        i_rst_n                = 1'b0;
        start                  = 1'b0;
        i_opcode               = '0;
        i_first_operand        = '0;
        i_second_operand       = '0;
        i_fallthrough_position = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed requests; the first one waits out the memory clearing pass
        send_instruction(OP_CONST, 32'h7fff_ffff, 16'h0001, 16'h0001);
        send_instruction(OP_CONST, 32'h8000_0000, 16'h0002, 16'h0002);
        send_instruction(OP_CONST, 32'hffff_ffff, 16'h0003, 16'h0003);
        // destination address wraps
        send_instruction(OP_CONST, 32'd5, 16'hff04, 16'h0004);
        send_instruction(OP_CONST, 32'd0, 16'h0006, 16'h0005);
        // overflowing add, source address wraps
        send_instruction(OP_ADD, 32'hffff_ff01, 16'h0001, 16'h0006);
        send_instruction(OP_SUB, 32'd4, 16'h0002, 16'h0007);
        send_instruction(OP_MUL, 32'd3, 16'h0004, 16'h0008);
        hold_off(3);
        // most negative word over minus one
        send_instruction(OP_CONST, 32'h8000_0000, 16'h0007, 16'h0009);
        send_instruction(OP_DIV, 32'd3, 16'h0007, 16'h000a);
        // zero divisor
        send_instruction(OP_DIV, 32'd6, 16'h0001, 16'hffff);
        // truncation toward zero
        send_instruction(OP_CONST, -32'd7, 16'h0008, 16'h000b);
        send_instruction(OP_CONST, 32'd2, 16'h0009, 16'h000c);
        send_instruction(OP_DIV, 32'd9, 16'h0008, 16'h000d);
        send_instruction(OP_MOVE, 32'h8000_0004, 16'h000a, 16'h000e);
        // indirect address wraps through a memory word
        send_instruction(OP_CONST, 32'h1234_5609, 16'h000c, 16'h000f);
        send_instruction(OP_ILOAD, 32'd12, 16'h000d, 16'h0010);
        send_instruction(OP_ISTORE, 32'd8, 16'h000c, 16'h0011);
        send_instruction(OP_JUMP, 32'hffff_ffff, 16'hffff, 16'h0000);
        // cjump taken, then not taken
        send_instruction(OP_CJUMP, 32'd6, 16'habcd, 16'h1234);
        send_instruction(OP_CJUMP, 32'd3, 16'habcd, 16'hffff);
        send_instruction(OP_HALT, 32'h5a5a_5a5a, 16'h5555, 16'h7777);
        send_instruction(OP_RESERVED_LAST, 32'hffff_ffff, 16'hffff, 16'hffff);
        send_instruction(OP_RESERVED_FIRST, 32'd0, 16'h0000, 16'h0000);

        // random requests; every third stretch of fifty runs without gaps
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n < RANDOM_REQUESTS - QUIET_TAIL && (n / 50) % 3 != 1 &&
                $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 9));
            send_random();
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (sb.outcomes_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog, also catches results that never arrive
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
rtl/core/ramx_pkg.sv
rtl/core/ramx_div.sv
rtl/core/ramx_dp.sv
rtl/core/ramx_ctrl.sv
rtl/core/ram_machine_instruction_execute_unit.sv
sim/testbench.sv
